// ----- hw/rtl/cbc_pkg.sv -----
package cbc_pkg;

  // Sample and word widths
  localparam int SampleW = 12;
  localparam int AdcBits = 12;
  localparam int RefW    = 21;
  localparam int GainW   = 32;
  localparam int DutyW   = 17;
  localparam int CmpW    = 10;
  localparam int ErrW    = 24;
  localparam int ProdW   = ErrW + GainW + 1;
  localparam int RndW    = ProdW + 1;
  localparam int IntW    = 40;
  localparam int PiOutW  = 34;
  localparam int VoltW   = 22;

  // Linear ADC scaling: gains in Q0.32, offsets in Q.32
  localparam logic [GainW-1:0]   VGain = 32'd12517698;
  localparam logic [GainW-1:0]   IGain = 32'd22191938;
  localparam logic [RndW-1:0]    VOffs = 58'd76265828;
  localparam logic [RndW-1:0]    IOffs = 58'd50709556515;
  localparam logic [RndW-1:0]    RoundHalf16 = 58'd32768;
  localparam logic [PiOutW:0]    RoundHalf14 = 35'd8192;

  // Outer loop limit: 8 A in Q.30
  localparam logic [PiOutW-1:0]  OuterHi = 34'h2_0000_0000;
  localparam logic [DutyW-1:0]   DutyFull = 17'd65536;
  localparam logic [CmpW-1:0]    DutyScale = 10'd1000;
  localparam logic [1:0]         NoMode = 2'd3;

  // Register reset values
  localparam logic [RefW-1:0]    CurrentRefRst = 21'd262144;
  localparam logic [RefW-1:0]    VoltageRefRst = 21'd262144;
  localparam logic [GainW-1:0]   KpCurrentRst  = 32'd10604338;
  localparam logic [GainW-1:0]   KiCurrentRst  = 32'd196377;
  localparam logic [GainW-1:0]   KpVoltageRst  = 32'd19647274;
  localparam logic [GainW-1:0]   KiVoltageRst  = 32'd357223;
  localparam logic [DutyW-1:0]   DutyMaxRst    = 17'd13107;

  typedef enum logic [2:0] {
    REG_LOOP_MODE   = 3'd0,
    REG_CURRENT_REF = 3'd1,
    REG_VOLTAGE_REF = 3'd2,
    REG_KP_CURRENT  = 3'd3,
    REG_KI_CURRENT  = 3'd4,
    REG_KP_VOLTAGE  = 3'd5,
    REG_KI_VOLTAGE  = 3'd6,
    REG_DUTY_MAX    = 3'd7
  } cbc_reg_e;

  typedef struct packed {
    logic             loop_mode;
    logic [RefW-1:0]  current_reference;
    logic [RefW-1:0]  voltage_reference;
    logic [GainW-1:0] kp_current;
    logic [GainW-1:0] ki_current;
    logic [GainW-1:0] kp_voltage;
    logic [GainW-1:0] ki_voltage;
    logic [DutyW-1:0] duty_max;
  } cbc_cfg_t;

  typedef enum logic [1:0] {
    MUL_VCODE  = 2'd0,
    MUL_ICODE  = 2'd1,
    MUL_ERR_KP = 2'd2,
    MUL_ERR_KI = 2'd3
  } cbc_mul_sel_e;

  typedef enum logic [1:0] {
    ADD_NONE  = 2'd0,
    ADD_VOFFS = 2'd1,
    ADD_IOFFS = 2'd2
  } cbc_add_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_MUL_V = 4'd1,
    ST_MUL_I = 4'd2,
    ST_AMPS  = 4'd3,
    ST_O_KI  = 4'd4,
    ST_O_INT = 4'd5,
    ST_O_SUM = 4'd6,
    ST_O_CMD = 4'd7,
    ST_I_KP  = 4'd8,
    ST_I_KI  = 4'd9,
    ST_I_INT = 4'd10,
    ST_I_SUM = 4'd11,
    ST_OUT   = 4'd12
  } cbc_state_e;

  typedef struct packed {
    logic         start;
    logic         mul_en;
    cbc_mul_sel_e mul_sel;
    cbc_add_sel_e add_sel;
    logic         outer;
    logic         ld_volts;
    logic         ld_amps;
    logic         ld_prop;
    logic         int_upd;
    logic         sum_upd;
    logic         ld_cmd_ref;
    logic         ld_cmd_pi;
    logic         ld_out;
  } cbc_cmd_t;

  typedef struct packed {
    logic cascade;
  } cbc_status_t;

endpackage

// ----- hw/rtl/cbc_cfg_regs.sv -----
module cbc_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output cbc_pkg::cbc_cfg_t    cfg_o
);
  import cbc_pkg::*;

  cbc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_mode         <= 1'b1;
      cfg_q.current_reference <= CurrentRefRst;
      cfg_q.voltage_reference <= VoltageRefRst;
      cfg_q.kp_current        <= KpCurrentRst;
      cfg_q.ki_current        <= KiCurrentRst;
      cfg_q.kp_voltage        <= KpVoltageRst;
      cfg_q.ki_voltage        <= KiVoltageRst;
      cfg_q.duty_max          <= DutyMaxRst;
    end else if (cfg_valid_i) begin
      case (cbc_reg_e'(cfg_index_i))
        REG_LOOP_MODE:   cfg_q.loop_mode         <= cfg_data_i[0];
        REG_CURRENT_REF: cfg_q.current_reference <= cfg_data_i[RefW-1:0];
        REG_VOLTAGE_REF: cfg_q.voltage_reference <= cfg_data_i[RefW-1:0];
        REG_KP_CURRENT:  cfg_q.kp_current        <= cfg_data_i;
        REG_KI_CURRENT:  cfg_q.ki_current        <= cfg_data_i;
        REG_KP_VOLTAGE:  cfg_q.kp_voltage        <= cfg_data_i;
        REG_KI_VOLTAGE:  cfg_q.ki_voltage        <= cfg_data_i;
        REG_DUTY_MAX:    cfg_q.duty_max          <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/cbc_datapath.sv -----
module cbc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbc_pkg::cbc_cmd_t             cmd_i,
  input  cbc_pkg::cbc_cfg_t             cfg_i,
  input  logic [cbc_pkg::SampleW-1:0]   voltage_sample_i,
  input  logic [cbc_pkg::SampleW-1:0]   current_sample_i,
  output cbc_pkg::cbc_status_t          status_o,
  output logic [cbc_pkg::CmpW-1:0]      duty_compare_o,
  output logic [cbc_pkg::RefW-1:0]      current_command_o,
  output logic                          inner_clamped_o,
  output logic                          outer_clamped_o
);
  import cbc_pkg::*;

  // Work registers
  logic [AdcBits-1:0]       vcode_q, icode_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [VoltW-1:0]  volts_q, amps_q;
  logic signed [IntW-1:0]   prop_q;
  logic [PiOutW-1:0]        pi_out_q;
  logic [RefW-1:0]          cmd_q;
  logic                     iclamp_q, oclamp_q;

  // Loop state
  logic signed [IntW-1:0]   cint_q, vint_q;
  logic                     cen_q, ven_q;
  logic [1:0]               prev_mode_q;

  // Result word
  logic [CmpW-1:0]          duty_cmp_q;
  logic [RefW-1:0]          cmd_out_q;
  logic                     iclamp_out_q, oclamp_out_q;

  logic signed [ErrW-1:0]   err_outer, err_inner, err_sel, mul_a;
  logic [GainW-1:0]         mul_b;
  logic [RndW-1:0]          addend;
  logic signed [RndW-1:0]   rnd_sum;
  logic signed [IntW-1:0]   rnd_val;
  logic signed [IntW-1:0]   integ_sel;
  logic                     en_sel;
  logic signed [IntW:0]     isum;
  logic signed [IntW-1:0]   integ_new;
  logic signed [IntW:0]     psum;
  logic [DutyW-1:0]         dmax;
  logic [PiOutW-1:0]        hi;
  logic [PiOutW-1:0]        pi_out_d;
  logic                     clamp_d;
  logic [PiOutW:0]          cmd_round;
  logic [DutyW+CmpW-1:0]    duty_prod;

  assign err_outer = $signed({3'b000, cfg_i.voltage_reference})
                   - $signed({{(ErrW-VoltW){volts_q[VoltW-1]}}, volts_q});
  assign err_inner = $signed({3'b000, cmd_q})
                   - $signed({{(ErrW-VoltW){amps_q[VoltW-1]}}, amps_q});
  assign err_sel = cmd_i.outer ? err_outer : err_inner;

  // Operand selection for the shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_VCODE: begin
        mul_a = $signed({{(ErrW-AdcBits){1'b0}}, vcode_q});
        mul_b = VGain;
      end
      MUL_ICODE: begin
        mul_a = $signed(ErrW'(0) - {{(ErrW-AdcBits){1'b0}}, icode_q});
        mul_b = IGain;
      end
      MUL_ERR_KP: begin
        mul_a = err_sel;
        mul_b = cmd_i.outer ? cfg_i.kp_voltage : cfg_i.kp_current;
      end
      MUL_ERR_KI: begin
        mul_a = err_sel;
        mul_b = cmd_i.outer ? cfg_i.ki_voltage : cfg_i.ki_current;
      end
      default: begin
        mul_a = err_sel;
        mul_b = cfg_i.kp_current;
      end
    endcase
  end

  // Add offset, round half up, drop 16 fraction bits
  always_comb begin
    case (cmd_i.add_sel)
      ADD_VOFFS: addend = VOffs;
      ADD_IOFFS: addend = IOffs;
      default:   addend = '0;
    endcase
  end

  assign rnd_sum = $signed({prod_q[ProdW-1], prod_q}) + $signed(addend)
                 + $signed(RoundHalf16);
  assign rnd_val = rnd_sum[IntW+15:16];

  // Saturating integrator update
  assign integ_sel = cmd_i.outer ? vint_q : cint_q;
  assign en_sel    = cmd_i.outer ? ven_q : cen_q;
  assign isum = {integ_sel[IntW-1], integ_sel} + {rnd_val[IntW-1], rnd_val};

  always_comb begin
    if (!isum[IntW] && isum[IntW-1]) begin
      integ_new = {1'b0, {(IntW-1){1'b1}}};
    end else if (isum[IntW] && !isum[IntW-1]) begin
      integ_new = {1'b1, {(IntW-1){1'b0}}};
    end else begin
      integ_new = isum[IntW-1:0];
    end
  end

  // Output clamp of the selected loop
  assign dmax = (cfg_i.duty_max > DutyFull) ? DutyFull : cfg_i.duty_max;
  assign hi   = cmd_i.outer ? OuterHi
                            : {{(PiOutW-DutyW-14){1'b0}}, dmax, 14'd0};
  assign psum = {prop_q[IntW-1], prop_q} + {integ_sel[IntW-1], integ_sel};

  always_comb begin
    if (psum > $signed({{(IntW+1-PiOutW){1'b0}}, hi})) begin
      pi_out_d = hi;
      clamp_d  = 1'b1;
    end else if (psum[IntW]) begin
      pi_out_d = '0;
      clamp_d  = 1'b1;
    end else begin
      pi_out_d = psum[PiOutW-1:0];
      clamp_d  = 1'b0;
    end
  end

  assign cmd_round = {1'b0, pi_out_q} + RoundHalf14;
  assign duty_prod = pi_out_q[DutyW+13:14] * DutyScale;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cint_q      <= '0;
      vint_q      <= '0;
      cen_q       <= 1'b1;
      ven_q       <= 1'b1;
      prev_mode_q <= NoMode;
    end else if (cmd_i.start) begin
      // Clear both loops on a mode change
      if ({1'b0, cfg_i.loop_mode} != prev_mode_q) begin
        cint_q <= '0;
        vint_q <= '0;
        cen_q  <= 1'b1;
        ven_q  <= 1'b1;
      end
      prev_mode_q <= {1'b0, cfg_i.loop_mode};
    end else if (cmd_i.int_upd) begin
      if (en_sel) begin
        if (cmd_i.outer) begin
          vint_q <= integ_new;
        end else begin
          cint_q <= integ_new;
        end
      end
    end else if (cmd_i.sum_upd) begin
      if (cmd_i.outer) begin
        ven_q <= !clamp_d;
      end else begin
        cen_q <= !clamp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      vcode_q  <= voltage_sample_i[AdcBits-1:0];
      icode_q  <= current_sample_i[AdcBits-1:0];
      oclamp_q <= 1'b0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(mul_a * $signed({1'b0, mul_b}));
    end
    if (cmd_i.ld_volts) begin
      volts_q <= rnd_val[VoltW-1:0];
    end
    if (cmd_i.ld_amps) begin
      amps_q <= rnd_val[VoltW-1:0];
    end
    if (cmd_i.ld_prop) begin
      prop_q <= rnd_val;
    end
    if (cmd_i.sum_upd) begin
      pi_out_q <= pi_out_d;
      if (cmd_i.outer) begin
        oclamp_q <= clamp_d;
      end else begin
        iclamp_q <= clamp_d;
      end
    end
    if (cmd_i.ld_cmd_ref) begin
      cmd_q <= cfg_i.current_reference;
    end else if (cmd_i.ld_cmd_pi) begin
      cmd_q <= cmd_round[RefW+13:14];
    end
    if (cmd_i.ld_out) begin
      duty_cmp_q   <= duty_prod[CmpW+15:16];
      cmd_out_q    <= cmd_q;
      iclamp_out_q <= iclamp_q;
      oclamp_out_q <= oclamp_q;
    end
  end

  assign status_o.cascade  = !cfg_i.loop_mode;
  assign duty_compare_o    = duty_cmp_q;
  assign current_command_o = cmd_out_q;
  assign inner_clamped_o   = iclamp_out_q;
  assign outer_clamped_o   = oclamp_out_q;

endmodule

// ----- hw/rtl/cbc_ctrl.sv -----
module cbc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  cbc_pkg::cbc_status_t  status_i,
  output cbc_pkg::cbc_cmd_t     cmd_o
);
  import cbc_pkg::*;

  cbc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_VCODE;
    cmd_o.add_sel = ADD_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = status_i.cascade ? ST_MUL_V : ST_MUL_I;
        end
      end
      ST_MUL_V: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VCODE;
        state_d = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_ICODE;
        cmd_o.add_sel  = ADD_VOFFS;
        cmd_o.ld_volts = status_i.cascade;
        cmd_o.ld_cmd_ref = !status_i.cascade;
        state_d = ST_AMPS;
      end
      ST_AMPS: begin
        // In cascade mode, launch the outer proportional product with current scaling
        cmd_o.add_sel = ADD_IOFFS;
        cmd_o.ld_amps = 1'b1;
        cmd_o.outer   = 1'b1;
        cmd_o.mul_sel = MUL_ERR_KP;
        cmd_o.mul_en  = status_i.cascade;
        state_d = status_i.cascade ? ST_O_KI : ST_I_KP;
      end
      ST_O_KI: begin
        cmd_o.outer   = 1'b1;
        cmd_o.ld_prop = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ERR_KI;
        state_d = ST_O_INT;
      end
      ST_O_INT: begin
        cmd_o.outer   = 1'b1;
        cmd_o.int_upd = 1'b1;
        state_d = ST_O_SUM;
      end
      ST_O_SUM: begin
        cmd_o.outer   = 1'b1;
        cmd_o.sum_upd = 1'b1;
        state_d = ST_O_CMD;
      end
      ST_O_CMD: begin
        cmd_o.ld_cmd_pi = 1'b1;
        state_d = ST_I_KP;
      end
      ST_I_KP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ERR_KP;
        state_d = ST_I_KI;
      end
      ST_I_KI: begin
        cmd_o.ld_prop = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ERR_KI;
        state_d = ST_I_INT;
      end
      ST_I_INT: begin
        cmd_o.int_upd = 1'b1;
        state_d = ST_I_SUM;
      end
      ST_I_SUM: begin
        cmd_o.sum_upd = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd_o.ld_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/cascaded_pi_buck_controller.sv -----
// Cascaded PI controller for a buck converter: one PWM compare word per
// sample pair.
// Input channel: in_valid_i/in_ready_o carry a word of one voltage and one
// current ADC sample. Output channel: out_valid_o/out_ready_i carry the
// duty compare value, the current command used by the inner loop and the
// clamp flags of both loops. Config channel: cfg_valid_i/cfg_ready_o write
// cfg_data_i to the register at cfg_index_i; it is always ready. The user is
// to write it only while the block is idle; the block does not enforce this.
// One word is worked on at a time by a single shared multiplier, at most one
// product a cycle. A word is accepted only in the idle state, and out_valid_o
// is registered and rises on the return to idle. A cascade word takes five
// more steps, for the voltage scaling and the outer loop.
// Reset loads the default gains and setpoints, clears both integrators and
// forces a loop clear on the first word. A stalled receiver holds the result
// word in the output register; the next input word is still accepted and
// processed, then waits in the last step until the output register is free.
module cascaded_pi_buck_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cbc_pkg::SampleW-1:0]   voltage_sample_i,
  input  logic [cbc_pkg::SampleW-1:0]   current_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cbc_pkg::CmpW-1:0]      duty_compare_o,
  output logic [cbc_pkg::RefW-1:0]      current_command_o,
  output logic                          inner_clamped_o,
  output logic                          outer_clamped_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import cbc_pkg::*;

  cbc_cfg_t    cfg;
  cbc_cmd_t    cmd;
  cbc_status_t status;

  // Register writes are always accepted
  assign cfg_ready_o = 1'b1;

  cbc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer: runs scaling, the outer loop in cascade mode and the inner loop
  cbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Shared multiplier, rounding, integrators, clamps and the result register
  cbc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .voltage_sample_i  (voltage_sample_i),
    .current_sample_i  (current_sample_i),
    .status_o          (status),
    .duty_compare_o    (duty_compare_o),
    .current_command_o (current_command_o),
    .inner_clamped_o   (inner_clamped_o),
    .outer_clamped_o   (outer_clamped_o)
  );

endmodule

// ----- tb/tb_cascaded_pi_buck_controller.sv -----
module tb_cascaded_pi_buck_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import cbc_pkg::*;

  // Linear ADC scaling: gains in Q0.32, offsets in Q.32
  localparam longint VoltGainQ32 = 64'sd12517698;
  localparam longint VoltOffsQ32 = 64'sd76265828;
  localparam longint AmpGainQ32  = 64'sd22191938;
  localparam longint AmpOffsQ32  = 64'sd50709556515;
  // 40-bit integrator limits and the 8 A outer clamp in Q.30
  localparam longint IntegMax    = 64'sd549755813887;
  localparam longint IntegMin    = -IntegMax - 64'sd1;
  localparam longint OuterHi30   = 64'sd8589934592;
  localparam longint DutyCeil    = 64'sd65536;
  localparam longint CmpScale    = 64'sd1000;

  // One result word of the block
  typedef struct {
    logic [CmpW-1:0] duty;
    logic [RefW-1:0] cmd;
    logic            inner;
    logic            outer;
  } pwm_word_t;

  // Clock, reset and ports
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [SampleW-1:0]  v_sample    = '0;
  logic [SampleW-1:0]  i_sample    = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [CmpW-1:0]     duty_cmp;
  logic [RefW-1:0]     cur_cmd;
  logic                inner_clamp;
  logic                outer_clamp;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index   = '0;
  logic [31:0]         cfg_data    = '0;

  // Shadow copy of the register file, loaded with the reset values
  logic                cfg_mode    = 1'b1;
  logic [RefW-1:0]     cfg_iref    = CurrentRefRst;
  logic [RefW-1:0]     cfg_vref    = VoltageRefRst;
  logic [GainW-1:0]    cfg_kpi     = KpCurrentRst;
  logic [GainW-1:0]    cfg_kii     = KiCurrentRst;
  logic [GainW-1:0]    cfg_kpv     = KpVoltageRst;
  logic [GainW-1:0]    cfg_kiv     = KiVoltageRst;
  logic [DutyW-1:0]    cfg_dmax    = DutyMaxRst;

  // Predicted loop state
  longint              i_integ     = 0;
  longint              v_integ     = 0;
  bit                  i_int_en    = 1'b1;
  bit                  v_int_en    = 1'b1;
  logic [1:0]          last_mode   = NoMode;

  pwm_word_t           pending_pwm_q[$];
  int                  mismatch_count = 0;
  bit                  idle_on     = 1'b1;
  int                  ready_hold  = 0;

  always #4 clk = ~clk;

  cascaded_pi_buck_controller u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .voltage_sample_i  (v_sample),
    .current_sample_i  (i_sample),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .duty_compare_o    (duty_cmp),
    .current_command_o (cur_cmd),
    .inner_clamped_o   (inner_clamp),
    .outer_clamped_o   (outer_clamp),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Narrow by n bits, rounding half toward plus infinity.
  function automatic longint rnd_shr(input longint x, input int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip40(input longint x);
    if (x > IntegMax) return IntegMax;
    if (x < IntegMin) return IntegMin;
    return x;
  endfunction

  // One PI update with clamping anti-windup; the result is in Q.30.
  function automatic longint pi_update(input longint err, input logic [31:0] kp,
                                       input logic [31:0] ki, inout longint acc,
                                       inout bit en, input longint hi,
                                       output logic clamped);
    longint prop;
    longint incr;
    longint total;
    prop = rnd_shr(err * longint'({32'd0, kp}), 16);
    incr = rnd_shr(err * longint'({32'd0, ki}), 16);
    // Skip integration for one step after a clamped output
    if (en) acc = clip40(acc + incr);
    total = prop + acc;
    if (total > hi) begin
      en = 1'b0;
      clamped = 1'b1;
      return hi;
    end
    if (total < 0) begin
      en = 1'b0;
      clamped = 1'b1;
      return 0;
    end
    en = 1'b1;
    clamped = 1'b0;
    return total;
  endfunction

  // Advance the predicted controller by one sample pair.
  function automatic pwm_word_t predict_pwm(input logic [SampleW-1:0] vcode,
                                            input logic [SampleW-1:0] icode);
    longint    volts;
    longint    amps;
    longint    cmd;
    longint    outer30;
    longint    duty30;
    longint    duty16;
    longint    dlim;
    logic      ic;
    logic      oc;
    pwm_word_t w;
    volts = rnd_shr(VoltOffsQ32 + longint'({52'd0, vcode}) * VoltGainQ32, 16);
    amps  = rnd_shr(AmpOffsQ32 - longint'({52'd0, icode}) * AmpGainQ32, 16);
    // A mode change (and the very first word) clears both loops
    if ({1'b0, cfg_mode} != last_mode) begin
      i_integ   = 0;
      v_integ   = 0;
      i_int_en  = 1'b1;
      v_int_en  = 1'b1;
      last_mode = {1'b0, cfg_mode};
    end
    oc = 1'b0;
    if (cfg_mode) begin
      // Current mode: voltage loop state is left alone
      cmd = longint'({43'd0, cfg_iref});
    end else begin
      outer30 = pi_update(longint'({43'd0, cfg_vref}) - volts, cfg_kpv, cfg_kiv,
                          v_integ, v_int_en, OuterHi30, oc);
      cmd = rnd_shr(outer30, 14);
    end
    // Duty limits above full scale act as full scale
    dlim = (cfg_dmax > DutyFull) ? DutyCeil : longint'({47'd0, cfg_dmax});
    duty30 = pi_update(cmd - amps, cfg_kpi, cfg_kii, i_integ, i_int_en,
                       dlim <<< 14, ic);
    duty16 = duty30 >>> 14;
    w.duty  = CmpW'((duty16 * CmpScale) >>> 16);
    w.cmd   = RefW'(cmd);
    w.inner = ic;
    w.outer = oc;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Idling and handshakes
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: drop ready for random stretches.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_result
    pwm_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pwm_q.size() == 0) begin
        $error("result word with no prediction waiting: duty_compare %0d", duty_cmp);
        mismatch_count++;
      end else begin
        want = pending_pwm_q.pop_front();
        if (duty_cmp !== want.duty) begin
          $error("duty_compare: expected %0d, got %0d", want.duty, duty_cmp);
          mismatch_count++;
        end
        if (cur_cmd !== want.cmd) begin
          $error("current_command: expected %0d, got %0d", want.cmd, cur_cmd);
          mismatch_count++;
        end
        if (inner_clamp !== want.inner) begin
          $error("inner_clamped: expected %0d, got %0d", want.inner, inner_clamp);
          mismatch_count++;
        end
        if (outer_clamp !== want.outer) begin
          $error("outer_clamped: expected %0d, got %0d", want.outer, outer_clamp);
          mismatch_count++;
        end
      end
    end
  end

  // Send one sample word; predict its result once it is accepted.
  task automatic send_samples(input logic [SampleW-1:0] vcode,
                              input logic [SampleW-1:0] icode);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    v_sample <= vcode;
    i_sample <= icode;
    do @(posedge clk); while (!in_ready);
    pending_pwm_q.push_back(predict_pwm(vcode, icode));
  endtask

  // Hold the input until every predicted word has come back, then let the
  // clock run on as a margin.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pwm_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(input cbc_reg_e idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOOP_MODE:   cfg_mode = data[0];
      REG_CURRENT_REF: cfg_iref = data[RefW-1:0];
      REG_VOLTAGE_REF: cfg_vref = data[RefW-1:0];
      REG_KP_CURRENT:  cfg_kpi  = data;
      REG_KI_CURRENT:  cfg_kii  = data;
      REG_KP_VOLTAGE:  cfg_kpv  = data;
      REG_KI_VOLTAGE:  cfg_kiv  = data;
      REG_DUTY_MAX:    cfg_dmax = data[DutyW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_gains(input logic [31:0] kpi, input logic [31:0] kii,
                            input logic [31:0] kpv, input logic [31:0] kiv);
    write_reg(REG_KP_CURRENT, kpi);
    write_reg(REG_KI_CURRENT, kii);
    write_reg(REG_KP_VOLTAGE, kpv);
    write_reg(REG_KI_VOLTAGE, kiv);
  endtask

  // ---------------------------------------------------------------------------
  // Random register values
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rand_gain();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 4) return $urandom;
    return $urandom_range(32'h0001_0000, 32'h0400_0000);
  endfunction

  // Setpoints: mostly in range, sometimes above it or with junk upper bits.
  function automatic logic [31:0] rand_setpoint();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom_range(1048577, 2097151);
    if (r == 2) return $urandom;
    return $urandom_range(0, 1048576);
  endfunction

  function automatic logic [31:0] rand_duty_max();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd65536;
    if (r == 2) return $urandom_range(65537, 131071);
    return $urandom_range(1, 65536);
  endfunction

  // Random walk of an ADC code, kept inside the converter range.
  function automatic int step_level(input int level);
    int nxt;
    nxt = level + int'($urandom_range(0, 64)) - 32;
    if (nxt < 0) return 0;
    if (nxt > 4095) return 4095;
    return nxt;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults in current mode; the first word forces a loop clear.
  task automatic test_reset_defaults();
    send_samples(12'd0, 12'd0);
    send_samples(12'd4095, 12'd4095);
    send_samples(12'd4095, 12'd0);
    send_samples(12'd0, 12'd4095);
    drain_results();
  endtask

  // Current mode with setpoint and duty limits at and beyond their ends.
  task automatic test_current_loop();
    write_reg(REG_CURRENT_REF, 32'd2097151);
    write_reg(REG_DUTY_MAX, 32'd131071);
    send_samples(12'd2048, 12'd4095);
    drain_results();
    write_reg(REG_CURRENT_REF, 32'd0);
    send_samples(12'd2048, 12'd0);
    drain_results();
    write_reg(REG_DUTY_MAX, 32'd0);
    write_reg(REG_CURRENT_REF, 32'd262144);
    send_samples(12'd1000, 12'd2000);
    drain_results();
    write_reg(REG_DUTY_MAX, 32'd65536);
    write_reg(REG_KP_CURRENT, 32'd0);
    write_reg(REG_KI_CURRENT, 32'hFFFF_FFFF);
    send_samples(12'd0, 12'd2300);
    send_samples(12'd0, 12'd2300);
    drain_results();
  endtask

  // Cascade mode: voltage setpoint at its ends, one voltage gain at a time.
  task automatic test_cascade_loop();
    load_gains(KpCurrentRst, KiCurrentRst, KpVoltageRst, KiVoltageRst);
    write_reg(REG_DUTY_MAX, DutyMaxRst);
    write_reg(REG_LOOP_MODE, 32'd0);
    write_reg(REG_VOLTAGE_REF, 32'd0);
    send_samples(12'd4095, 12'd2286);
    drain_results();
    write_reg(REG_VOLTAGE_REF, 32'd2097151);
    send_samples(12'd0, 12'd2286);
    drain_results();
    write_reg(REG_VOLTAGE_REF, 32'd1048576);
    write_reg(REG_KP_VOLTAGE, 32'hFFFF_FFFF);
    write_reg(REG_KI_VOLTAGE, 32'd0);
    send_samples(12'd3000, 12'd1000);
    drain_results();
    write_reg(REG_KP_VOLTAGE, 32'd0);
    write_reg(REG_KI_VOLTAGE, 32'hFFFF_FFFF);
    send_samples(12'd3000, 12'd1000);
    send_samples(12'd3000, 12'd1000);
    drain_results();
  endtask

  // Largest gains with the voltage error swinging sign every word, to pump
  // both integrators toward their 40-bit limits.
  task automatic test_integrator_limits();
    load_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(REG_VOLTAGE_REF, 32'd393216);
    write_reg(REG_DUTY_MAX, 32'd65536);
    repeat (3) begin
      send_samples(12'd0, 12'd4095);
      send_samples(12'd4095, 12'd0);
    end
    drain_results();
  endtask

  // Mode switches clear both loops; rewriting the same mode does not.
  task automatic test_mode_change();
    load_gains(KpCurrentRst, KiCurrentRst, KpVoltageRst, KiVoltageRst);
    write_reg(REG_LOOP_MODE, 32'd1);
    send_samples(12'd2000, 12'd2000);
    drain_results();
    write_reg(REG_LOOP_MODE, 32'd1);
    send_samples(12'd2000, 12'd2000);
    drain_results();
    write_reg(REG_LOOP_MODE, 32'd0);
    send_samples(12'd1200, 12'd2100);
    send_samples(12'd1300, 12'd2200);
    drain_results();
    write_reg(REG_LOOP_MODE, 32'd1);
    send_samples(12'd1300, 12'd2200);
    drain_results();
  endtask

  // Phases of random settings; most phases walk the samples slowly so the
  // loops settle and hit their clamps, the rest throw random codes.
  task automatic test_random_operation();
    int sent;
    int phase_len;
    int vlevel;
    int ilevel;
    bit walk;
    sent = 0;
    while (sent < 1100) begin
      write_reg(REG_LOOP_MODE, $urandom_range(1));
      write_reg(REG_CURRENT_REF, rand_setpoint());
      write_reg(REG_VOLTAGE_REF, rand_setpoint());
      load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
      write_reg(REG_DUTY_MAX, rand_duty_max());
      idle_on   = ($urandom_range(3) != 0);
      walk      = ($urandom_range(3) != 0);
      phase_len = $urandom_range(40, 120);
      vlevel    = $urandom_range(4095);
      ilevel    = $urandom_range(4095);
      repeat (phase_len) begin
        if (walk) begin
          vlevel = step_level(vlevel);
          ilevel = step_level(ilevel);
        end else begin
          vlevel = $urandom_range(4095);
          ilevel = $urandom_range(4095);
        end
        send_samples(vlevel[SampleW-1:0], ilevel[SampleW-1:0]);
        sent++;
        // Now and then hold the input until the block has emptied
        if ($urandom_range(60) == 0) drain_results();
      end
      drain_results();
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_current_loop();
    test_cascade_loop();
    test_integrator_limits();
    test_mode_change();
    test_random_operation();
    drain_results();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal one.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
